@@ rtl/assert_macros.svh @@
// Assertion macros shared by the line-fit RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lslf_pkg.sv @@
// Package for the least-squares line-fit unit: sizes, constants, arithmetic unit types.
// No dependencies.
package lslf_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 32;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SX_W   = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W - 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int P_W    = SQ_W + SX_W + 1;
  localparam int NUM_W  = P_W + FRAC_BITS;
  localparam int Q_W    = OUT_W + 1;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int OP_W   = 3;

  localparam logic [Q_W-1:0]   NEG_LIM = Q_W'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] RES_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] RES_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef enum logic [2:0] {
    ARITH_IDLE,
    ARITH_CLEAR,
    ARITH_MUL_LOAD,
    ARITH_MUL_STEP,
    ARITH_SAVE_D,
    ARITH_DIV_LOAD,
    ARITH_DIV_STEP
  } arith_cmd_t;

  typedef struct packed {
    arith_cmd_t             cmd;
    logic signed [P_W-1:0]  mcand;
    logic signed [SX_W-1:0] mplier;
    logic                   sub;
  } arith_ctl_t;

  typedef struct packed {
    logic signed [P_W-1:0] acc;
    logic [Q_W-1:0]        quot;
    logic                  qovf;
    logic                  neg;
  } arith_sts_t;

endpackage

@@ rtl/lslf_if.sv @@
// Point and fit-result channels of the line-fit unit: valid/ready plus payload.
// Depends on lslf_pkg for the sample and result widths.
interface lslf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lslf_pkg::SAMPLE_BITS-1:0] x_sample;
  logic signed [lslf_pkg::SAMPLE_BITS-1:0] y_sample;
  logic                                   last_point;

  modport source (output valid, x_sample, y_sample, last_point, input ready);
  modport sink   (input valid, x_sample, y_sample, last_point, output ready);
endinterface

interface lslf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lslf_pkg::OUT_W-1:0] slope;
  logic signed [lslf_pkg::OUT_W-1:0] intercept;
  logic                             degenerate;
  logic                             overflowed;

  modport source (output valid, slope, intercept, degenerate, overflowed, input ready);
  modport sink   (input valid, slope, intercept, degenerate, overflowed, output ready);
endinterface

@@ rtl/least_squares_line_fit_unit.sv @@
// Least-squares line fit: accumulates points, then fits slope and intercept in Q16.16.
// Ordinary point: accepted, summed next cycle, then ready again once back in idle.
// Last point: six shift-add products and two restoring divisions run on the one shared
// adder in lslf_arith. Degenerate sets go to the output after the denominator check.
// Synchronous active-low reset clears sums.
// Depends on lslf_pkg, lslf_if, lslf_arith and assert_macros.svh.
`include "assert_macros.svh"

module least_squares_line_fit_unit (
  input  logic              clk,
  input  logic              rst_n,
  lslf_in_if.sink           in_pt,
  lslf_out_if.source        out_fit
);

  localparam int SB  = lslf_pkg::SAMPLE_BITS;
  localparam int CW  = lslf_pkg::CNT_W;
  localparam int XW  = lslf_pkg::SX_W;
  localparam int QQW = lslf_pkg::SQ_W;
  localparam int RW  = lslf_pkg::PROD_W;
  localparam int PW  = lslf_pkg::P_W;
  localparam int NW  = lslf_pkg::NUM_W;
  localparam int QW  = lslf_pkg::Q_W;
  localparam int OW  = lslf_pkg::OUT_W;
  localparam int SW  = lslf_pkg::STEP_W;
  localparam int OPW = lslf_pkg::OP_W;

  localparam logic [OPW-1:0] OP_N_SXX  = 3'd0;
  localparam logic [OPW-1:0] OP_SX_SX  = 3'd1;
  localparam logic [OPW-1:0] OP_N_SXY  = 3'd2;
  localparam logic [OPW-1:0] OP_SX_SY  = 3'd3;
  localparam logic [OPW-1:0] OP_SXX_SY = 3'd4;
  localparam logic [OPW-1:0] OP_SX_SXY = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ACC   = 9'b000000010,
    S_MLOAD = 9'b000000100,
    S_MSTEP = 9'b000001000,
    S_DCHK  = 9'b000010000,
    S_DLOAD = 9'b000100000,
    S_DSTEP = 9'b001000000,
    S_DFIN  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r;
  logic signed [XW-1:0]  sum_x_r;
  logic signed [XW-1:0]  sum_y_r;
  logic signed [QQW-1:0] sum_xx_r;
  logic signed [QQW-1:0] sum_xy_r;
  logic                  dropped_r;
  logic [OPW-1:0]        op_r;
  logic [SW-1:0]         step_r;
  logic                  sat_r;
  logic                  out_valid_r;

  logic signed [SB-1:0]  x_r;
  logic signed [SB-1:0]  y_r;
  logic signed [RW-1:0]  prod_xx_r;
  logic signed [RW-1:0]  prod_xy_r;
  logic                  last_r;
  logic [OW-1:0]         slope_r;
  logic [OW-1:0]         icpt_r;
  logic                  degen_r;
  logic [OW-1:0]         out_slope_r;
  logic [OW-1:0]         out_icpt_r;
  logic                  out_degen_r;
  logic                  out_ovf_r;

  lslf_pkg::arith_ctl_t  actl;
  lslf_pkg::arith_sts_t  asts;

  logic                  in_fire;
  logic                  out_free;
  logic                  mul_end;
  logic                  div_end;
  logic                  fit_degen;
  logic [QW-1:0]         fin_neg;
  logic                  fin_sat;
  logic [OW-1:0]         fin_val;

  lslf_arith u_arith (
    .clk (clk),
    .ctl (actl),
    .sts (asts)
  );

  assign in_pt.ready = (state_r == S_IDLE);
  assign in_fire     = in_pt.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_fit.ready;
  assign mul_end     = (step_r == SW'(XW - 1));
  assign div_end     = (step_r == SW'(NW - 1));
  assign fit_degen   = (count_r < CW'(2)) || (asts.acc == '0);

  always_comb begin
    actl.cmd    = lslf_pkg::ARITH_IDLE;
    actl.mcand  = PW'(sum_xy_r);
    actl.mplier = sum_x_r;
    actl.sub    = 1'b1;
    case (op_r)
      OP_N_SXX: begin
        actl.mcand  = PW'(sum_xx_r);
        actl.mplier = XW'({1'b0, count_r});
        actl.sub    = 1'b0;
      end
      OP_SX_SX: begin
        actl.mcand  = PW'(sum_x_r);
        actl.mplier = sum_x_r;
        actl.sub    = 1'b1;
      end
      OP_N_SXY: begin
        actl.mcand  = PW'(sum_xy_r);
        actl.mplier = XW'({1'b0, count_r});
        actl.sub    = 1'b0;
      end
      OP_SX_SY: begin
        actl.mcand  = PW'(sum_y_r);
        actl.mplier = sum_x_r;
        actl.sub    = 1'b1;
      end
      OP_SXX_SY: begin
        actl.mcand  = PW'(sum_xx_r);
        actl.mplier = sum_y_r;
        actl.sub    = 1'b0;
      end
      default: ;
    endcase
    case (state_r)
      S_ACC:   actl.cmd = lslf_pkg::ARITH_CLEAR;
      S_MLOAD: actl.cmd = lslf_pkg::ARITH_MUL_LOAD;
      S_MSTEP: actl.cmd = lslf_pkg::ARITH_MUL_STEP;
      S_DCHK:  actl.cmd = lslf_pkg::ARITH_SAVE_D;
      S_DLOAD: actl.cmd = lslf_pkg::ARITH_DIV_LOAD;
      S_DSTEP: actl.cmd = lslf_pkg::ARITH_DIV_STEP;
      default: actl.cmd = lslf_pkg::ARITH_IDLE;
    endcase
  end

  always_comb begin
    fin_neg = QW'(0) - asts.quot;
    if (asts.neg) begin
      fin_sat = asts.qovf || (asts.quot > lslf_pkg::NEG_LIM);
      fin_val = fin_sat ? lslf_pkg::RES_MIN : fin_neg[OW-1:0];
    end else begin
      fin_sat = asts.qovf || (asts.quot[QW-1:QW-2] != 2'b00);
      fin_val = fin_sat ? lslf_pkg::RES_MAX : asts.quot[OW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_ACC;
      S_ACC:   state_nxt = last_r ? S_MLOAD : S_IDLE;
      S_MLOAD: state_nxt = S_MSTEP;
      S_MSTEP: begin
        if (mul_end) begin
          if (op_r == OP_SX_SX) begin
            state_nxt = S_DCHK;
          end else if (op_r == OP_SX_SY || op_r == OP_SX_SXY) begin
            state_nxt = S_DLOAD;
          end else begin
            state_nxt = S_MLOAD;
          end
        end
      end
      S_DCHK:  state_nxt = fit_degen ? S_OUT : S_MLOAD;
      S_DLOAD: state_nxt = S_DSTEP;
      S_DSTEP: if (div_end) state_nxt = S_DFIN;
      S_DFIN:  state_nxt = (op_r == OP_SXX_SY) ? S_MLOAD : S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_xx_r    <= '0;
      sum_xy_r    <= '0;
      dropped_r   <= 1'b0;
      op_r        <= OP_N_SXX;
      step_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_ACC: begin
          if (count_r < CW'(lslf_pkg::MAX_POINTS)) begin
            count_r  <= count_r + CW'(1);
            sum_x_r  <= sum_x_r + XW'(x_r);
            sum_y_r  <= sum_y_r + XW'(y_r);
            sum_xx_r <= sum_xx_r + QQW'(prod_xx_r);
            sum_xy_r <= sum_xy_r + QQW'(prod_xy_r);
          end else begin
            dropped_r <= 1'b1;
          end
          op_r   <= OP_N_SXX;
          step_r <= '0;
          sat_r  <= 1'b0;
        end
        S_MSTEP: begin
          if (mul_end) begin
            step_r <= '0;
            op_r   <= op_r + OPW'(1);
          end else begin
            step_r <= step_r + SW'(1);
          end
        end
        S_DSTEP: begin
          step_r <= div_end ? '0 : step_r + SW'(1);
        end
        S_DFIN: begin
          sat_r <= sat_r | fin_sat;
        end
        S_OUT: begin
          if (out_free) begin
            count_r   <= '0;
            sum_x_r   <= '0;
            sum_y_r   <= '0;
            sum_xx_r  <= '0;
            sum_xy_r  <= '0;
            dropped_r <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fit.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r       <= in_pt.x_sample;
      y_r       <= in_pt.y_sample;
      prod_xx_r <= in_pt.x_sample * in_pt.x_sample;
      prod_xy_r <= in_pt.x_sample * in_pt.y_sample;
      last_r    <= in_pt.last_point;
    end
    if (state_r == S_DCHK) begin
      degen_r <= fit_degen;
      if (fit_degen) begin
        slope_r <= '0;
        icpt_r  <= '0;
      end
    end
    if (state_r == S_DFIN) begin
      if (op_r == OP_SXX_SY) begin
        slope_r <= fin_val;
      end else begin
        icpt_r <= fin_val;
      end
    end
    if (state_r == S_OUT && out_free) begin
      out_slope_r <= slope_r;
      out_icpt_r  <= icpt_r;
      out_degen_r <= degen_r;
      out_ovf_r   <= sat_r | dropped_r;
    end
  end

  assign out_fit.valid      = out_valid_r;
  assign out_fit.slope      = out_slope_r;
  assign out_fit.intercept  = out_icpt_r;
  assign out_fit.degenerate = out_degen_r;
  assign out_fit.overflowed = out_ovf_r;

  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(lslf_pkg::MAX_POINTS), "point count above limit")
  `ASSERT_IMPL(a_drop_full, $rose(dropped_r), count_r == CW'(lslf_pkg::MAX_POINTS), "drop below limit")
  `ASSERT_NEXT(a_out_stall, state_r == S_OUT && !out_free, state_r == S_OUT, "result lost on stall")
  `ASSERT_NEXT(a_sums_clear, state_r == S_OUT && out_free, count_r == '0 && !dropped_r, "sums not cleared")
  `ASSERT_IMPL(a_degen_zero, out_valid_r && out_degen_r, out_slope_r == '0 && out_icpt_r == '0, "degenerate result not zero")

endmodule

@@ rtl/lslf_arith.sv @@
// Shared iterative arithmetic unit: shift-add multiply-accumulate and restoring divide,
// both on one wide adder. Depends on lslf_pkg.
module lslf_arith (
  input  logic                 clk,
  input  lslf_pkg::arith_ctl_t ctl,
  output lslf_pkg::arith_sts_t sts
);

  localparam int PW = lslf_pkg::P_W;
  localparam int MW = lslf_pkg::SX_W;
  localparam int NW = lslf_pkg::NUM_W;
  localparam int QW = lslf_pkg::Q_W;

  logic [PW-1:0] acc_r;
  logic [PW-1:0] mcand_r;
  logic [PW-1:0] d_r;
  logic [PW-1:0] rem_r;
  logic [MW-1:0] mplier_r;
  logic [NW-1:0] num_r;
  logic [QW-1:0] quot_r;
  logic          qovf_r;
  logic          neg_r;

  logic [MW-1:0] mplier_mag;
  logic          mul_neg;
  logic [PW-1:0] rem_sh;
  logic [PW-1:0] add_a;
  logic [PW-1:0] add_b;
  logic          add_inv;
  logic [PW:0]   add_sum;
  logic          carry;

  assign mul_neg    = ctl.mplier[MW-1] ^ ctl.sub;
  assign mplier_mag = ctl.mplier[MW-1] ? (~ctl.mplier + MW'(1)) : ctl.mplier;
  assign rem_sh     = {rem_r[PW-2:0], num_r[NW-1]};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_inv = 1'b0;
    case (ctl.cmd)
      lslf_pkg::ARITH_MUL_LOAD: begin
        add_b   = ctl.mcand;
        add_inv = mul_neg;
      end
      lslf_pkg::ARITH_MUL_STEP: begin
        add_a = acc_r;
        add_b = mplier_r[0] ? mcand_r : '0;
      end
      lslf_pkg::ARITH_DIV_LOAD: begin
        add_b   = acc_r;
        add_inv = acc_r[PW-1];
      end
      lslf_pkg::ARITH_DIV_STEP: begin
        add_a   = rem_sh;
        add_b   = d_r;
        add_inv = 1'b1;
      end
      default: ;
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b ^ {PW{add_inv}}} + (PW + 1)'(add_inv);
  end

  assign carry = add_sum[PW];

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      lslf_pkg::ARITH_CLEAR: begin
        acc_r <= '0;
      end
      lslf_pkg::ARITH_MUL_LOAD: begin
        mcand_r  <= add_sum[PW-1:0];
        mplier_r <= mplier_mag;
      end
      lslf_pkg::ARITH_MUL_STEP: begin
        acc_r    <= add_sum[PW-1:0];
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end
      lslf_pkg::ARITH_SAVE_D: begin
        d_r   <= acc_r;
        acc_r <= '0;
      end
      lslf_pkg::ARITH_DIV_LOAD: begin
        num_r  <= NW'(add_sum[PW-1:0]) << lslf_pkg::FRAC_BITS;
        neg_r  <= acc_r[PW-1];
        rem_r  <= '0;
        quot_r <= '0;
        qovf_r <= 1'b0;
        acc_r  <= '0;
      end
      lslf_pkg::ARITH_DIV_STEP: begin
        rem_r  <= carry ? add_sum[PW-1:0] : rem_sh;
        num_r  <= num_r << 1;
        quot_r <= {quot_r[QW-2:0], carry};
        qovf_r <= qovf_r | quot_r[QW-1];
      end
      default: ;
    endcase
  end

  assign sts.acc  = acc_r;
  assign sts.quot = quot_r;
  assign sts.qovf = qovf_r;
  assign sts.neg  = neg_r;

endmodule
